### design/alpha_class_rle_segment_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// Alpha-class RLE segment encoder: assertion macros
// Shared property wrappers; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ALPHA_CLASS_RLE_SEGMENT_ENCODER_TOP_DEFINES_SVH
`define ALPHA_CLASS_RLE_SEGMENT_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ACRLE_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACRLE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### design/acrle_pkg.sv
// ----------------------------------------------------------------------------
// acrle_pkg
// Shared types, widths and constants of the alpha-class RLE segment encoder.
// ----------------------------------------------------------------------------
package acrle_pkg;

  localparam int SEG_WIDTH_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int PIXEL_W   = 32;
  localparam int WORD_W    = 16;
  localparam int CLS_W     = 3;
  localparam int HDR_LEN_W = 13;   // class sits in bits 15:13 of a run header, above the length
  localparam int SEGW_W    = 6;
  localparam int VIS_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 56;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR  = 1'b1;

  // alpha class thresholds (upper bound of each class, inclusive)
  localparam logic [7:0] ALPHA_T0 = 8'd31;
  localparam logic [7:0] ALPHA_T1 = 8'd95;
  localparam logic [7:0] ALPHA_T2 = 8'd159;
  localparam logic [7:0] ALPHA_T3 = 8'd223;

  localparam logic [CLS_W-1:0] CLS_CLEAR = 3'd0;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] rgb;
    logic [CLS_W-1:0]  cls;
    logic              close;   // last pixel of the segment
    logic [VIS_W-1:0]  vis;     // visible total after this pixel
  } entry_t;

  function automatic logic [CLS_W-1:0] alpha_class(input logic [7:0] a);
    logic [CLS_W-1:0] c;
    if (a <= ALPHA_T0) begin
      c = 3'd0;
    end else if (a <= ALPHA_T1) begin
      c = 3'd1;
    end else if (a <= ALPHA_T2) begin
      c = 3'd2;
    end else if (a <= ALPHA_T3) begin
      c = 3'd3;
    end else begin
      c = 3'd4;
    end
    return c;
  endfunction

endpackage

### design/acrle_front.sv
// ----------------------------------------------------------------------------
// acrle_front
// Accept pixels, convert to RGB565, apply color key, classify alpha, keep the
// visible count and segment position, push one entry per pixel.
// ----------------------------------------------------------------------------
module acrle_front #(
  parameter int SEG_WIDTH = acrle_pkg::SEG_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [acrle_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [acrle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [acrle_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tlast,
  input  logic                                s_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output acrle_pkg::entry_t                   q_entry
);

  localparam int IW = (SEG_WIDTH > 1) ? $clog2(SEG_WIDTH) : 1;

  logic                           key_enable;
  logic [acrle_pkg::WORD_W-1:0]   key_color;
  logic [acrle_pkg::VIS_W-1:0]    vis;
  logic [IW-1:0]                  fill;

  logic [acrle_pkg::WORD_W-1:0]   rgb_raw;
  logic                           keyed;
  logic [7:0]                     alpha;
  logic [acrle_pkg::CLS_W-1:0]    cls;
  logic [acrle_pkg::VIS_W-1:0]    vis_base;
  logic [acrle_pkg::VIS_W-1:0]    vis_next;
  logic                           close;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  assign rgb_raw  = {s_tdata[7:3], s_tdata[15:10], s_tdata[23:19]};
  assign keyed    = key_enable && (rgb_raw == key_color);
  assign alpha    = keyed ? 8'd0 : s_tdata[31:24];
  assign cls      = acrle_pkg::alpha_class(alpha);
  assign vis_base = s_tuser ? '0 : vis;
  assign vis_next = ((cls != acrle_pkg::CLS_CLEAR) && (vis_base != '1)) ?
                    vis_base + acrle_pkg::VIS_W'(1) : vis_base;
  assign close    = s_tlast || (fill == IW'(SEG_WIDTH - 1));

  assign q_entry.rgb   = keyed ? '0 : rgb_raw;
  assign q_entry.cls   = cls;
  assign q_entry.close = close;
  assign q_entry.vis   = vis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable <= 1'b0;
      key_color  <= '0;
      vis        <= '0;
      fill       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          acrle_pkg::CFG_KEY_ENABLE: key_enable <= cfg_wdata[0];
          acrle_pkg::CFG_KEY_COLOR:  key_color  <= cfg_wdata;
          default: ;
        endcase
      end
      if (q_push) begin
        vis  <= vis_next;
        fill <= close ? '0 : fill + IW'(1);
      end
    end
  end

endmodule

### design/acrle_fifo.sv
// ----------------------------------------------------------------------------
// acrle_fifo
// Short entry queue between the classifier and the segment emitter.
// ----------------------------------------------------------------------------
module acrle_fifo #(
  parameter int DEPTH = acrle_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  acrle_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output acrle_pkg::entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  acrle_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     count;

  assign full      = (count == NW'(DEPTH));
  assign valid     = (count != '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

### design/acrle_back.sv
// ----------------------------------------------------------------------------
// acrle_back
// Collect one segment with its run table, then emit the run count, run
// headers and color words through a registered output stage.
// ----------------------------------------------------------------------------
`include "alpha_class_rle_segment_encoder_top_defines.svh"

module acrle_back #(
  parameter int SEG_WIDTH = acrle_pkg::SEG_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  acrle_pkg::entry_t                 q_entry,
  output logic                              q_pop,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [acrle_pkg::WORD_W-1:0]      m_word,
  output logic                              m_last,
  output logic [acrle_pkg::SEGW_W-1:0]      m_seg_words,
  output logic [acrle_pkg::VIS_W-1:0]       m_vis
);

  localparam int IW    = (SEG_WIDTH > 1) ? $clog2(SEG_WIDTH) : 1;
  localparam int CW    = $clog2(SEG_WIDTH + 1);
  localparam int WW    = acrle_pkg::WORD_W;
  localparam int LEN_W = acrle_pkg::HDR_LEN_W;
  localparam int SW    = acrle_pkg::SEGW_W;

  typedef enum logic [1:0] {ST_FILL, ST_COUNT, ST_HDR, ST_PIX} state_t;

  typedef struct packed {
    logic [acrle_pkg::CLS_W-1:0] cls;
    logic [CW-1:0]               len;
  } run_t;

  logic [WW-1:0] pix_mem [SEG_WIDTH];
  run_t          run_mem [SEG_WIDTH];

  state_t                       state;
  logic [IW-1:0]                wr_idx;
  logic [CW-1:0]                runs;
  logic [CW-1:0]                vis_cnt;
  logic [acrle_pkg::CLS_W-1:0]  cur_cls;
  logic [CW-1:0]                cur_len;
  logic [IW-1:0]                run_idx;
  logic [IW-1:0]                pix_idx;
  logic [CW-1:0]                pix_left;
  logic [acrle_pkg::VIS_W-1:0]  vis_hold;

  logic          can_emit;
  logic          emit;
  logic          first;
  logic          same;
  logic          last_run;
  run_t          run_cur;
  logic          run_clear;
  logic [SW-1:0] seg_total;

  assign q_pop     = (state == ST_FILL) && q_valid;
  assign can_emit  = !m_valid || m_ready;
  assign emit      = (state != ST_FILL) && can_emit;
  assign first     = (wr_idx == '0);
  assign same      = (cur_cls == q_entry.cls);
  assign last_run  = ((CW'(run_idx) + CW'(1)) == runs);
  assign run_cur   = last_run ? run_t'{cls: cur_cls, len: cur_len} : run_mem[run_idx];
  assign run_clear = (run_cur.cls == acrle_pkg::CLS_CLEAR);
  assign seg_total = SW'(1) + SW'(runs) + SW'(vis_cnt);

  // segment storage: colors by position, closed runs by run number
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pix_mem[wr_idx] <= q_entry.rgb;
      if (!first && !same) begin
        run_mem[IW'(runs - CW'(1))] <= '{cls: cur_cls, len: cur_len};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      m_valid <= 1'b0;
      wr_idx  <= '0;
    end else begin
      // load a new word or hold the current one until it is taken
      m_valid <= emit || (m_valid && !m_ready);
      unique case (state)
        ST_FILL: begin
          if (q_valid) begin
            vis_hold <= q_entry.vis;
            wr_idx   <= q_entry.close ? '0 : wr_idx + IW'(1);
            if (first) begin
              cur_cls <= q_entry.cls;
              cur_len <= CW'(1);
              runs    <= CW'(1);
              vis_cnt <= CW'(q_entry.cls != acrle_pkg::CLS_CLEAR);
            end else begin
              if (same) begin
                cur_len <= cur_len + CW'(1);
              end else begin
                cur_cls <= q_entry.cls;
                cur_len <= CW'(1);
                runs    <= runs + CW'(1);
              end
              vis_cnt <= vis_cnt + CW'(q_entry.cls != acrle_pkg::CLS_CLEAR);
            end
            if (q_entry.close) begin
              state <= ST_COUNT;
            end
          end
        end
        ST_COUNT: begin
          if (can_emit) begin
            m_word      <= WW'(runs);
            m_last      <= 1'b0;
            m_seg_words <= '0;
            m_vis       <= vis_hold;
            run_idx     <= '0;
            pix_idx     <= '0;
            state       <= ST_HDR;
          end
        end
        ST_HDR: begin
          if (can_emit) begin
            m_word      <= {run_cur.cls, LEN_W'(run_cur.len)};
            m_last      <= last_run && run_clear;
            m_seg_words <= (last_run && run_clear) ? seg_total : '0;
            if (!run_clear) begin
              pix_left <= run_cur.len;
              state    <= ST_PIX;
            end else begin
              pix_idx <= pix_idx + IW'(run_cur.len);
              run_idx <= run_idx + IW'(1);
              if (last_run) begin
                state <= ST_FILL;
              end
            end
          end
        end
        ST_PIX: begin
          if (can_emit) begin
            m_word      <= pix_mem[pix_idx];
            m_last      <= last_run && (pix_left == CW'(1));
            m_seg_words <= (last_run && (pix_left == CW'(1))) ? seg_total : '0;
            pix_idx     <= pix_idx + IW'(1);
            pix_left    <= pix_left - CW'(1);
            if (pix_left == CW'(1)) begin
              if (last_run) begin
                state <= ST_FILL;
              end else begin
                run_idx <= run_idx + IW'(1);
                state   <= ST_HDR;
              end
            end
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  `ACRLE_ASSERT_NOW(a_no_pop_while_emit, state != ST_FILL, !q_pop, "entry taken during emission")
  `ACRLE_ASSERT_NOW(a_pix_run_nonempty, state == ST_PIX, pix_left != '0, "color run with no pixels left")
  `ACRLE_ASSERT_NEXT(a_close_starts_emit, q_pop && q_entry.close, state == ST_COUNT, "closed segment not emitted")

endmodule

### design/alpha_class_rle_segment_encoder_top.sv
// ----------------------------------------------------------------------------
// alpha_class_rle_segment_encoder_top
// Encode ABGR pixels into RGB565 segments with alpha-class run lengths.
// ----------------------------------------------------------------------------
// Pixels enter one per transfer on the s_ side; each is cut to RGB565,
// optionally keyed to fully transparent, and given one of five alpha classes.
// Rows are split into segments of SEG_WIDTH pixels (or fewer at row end).
// For each segment the m_ side carries a run-count word, then per run of equal
// class a header (class in bits 15:13, length below), followed by the run's
// color words unless the class is transparent. The final word of a segment
// has m_tlast set and carries the segment's word count; every word carries the
// saturating visible pixel total as of the segment's closing pixel.
// Timing: the front takes one pixel per cycle into a QUEUE_DEPTH-entry queue.
// The back moves one queued pixel per cycle into its segment buffer, then
// emits 1 + runs + visible-pixel words at one word per cycle while m_tready
// allows; it does not fill while emitting. This emitter thus sets the
// sustained rate. Input stalls only when the queue is full.
// Configuration: cfg_addr 0 = key_enable (bit 0), 1 = key_color (RGB565);
// write only while the block is idle. No clearing pass after reset.
module alpha_class_rle_segment_encoder_top #(
  parameter int SEG_WIDTH   = acrle_pkg::SEG_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = acrle_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [acrle_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [acrle_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [acrle_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] pixel_abgr
  input  logic                              s_tlast,   // row_end
  input  logic                              s_tuser,   // image_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [acrle_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] word,
                                                       // [21:16] segment_words,
                                                       // [53:22] visible_total,
                                                       // [55:54] zero
  output logic                              m_tlast    // last_of_segment
);

  acrle_pkg::entry_t                 push_entry;
  acrle_pkg::entry_t                 pop_entry;
  logic                              push;
  logic                              pop;
  logic                              q_full;
  logic                              q_valid;
  logic [acrle_pkg::WORD_W-1:0]      word;
  logic [acrle_pkg::SEGW_W-1:0]      seg_words;
  logic [acrle_pkg::VIS_W-1:0]       vis_total;

  // classify and count; hold input when the queue is full
  acrle_front #(
    .SEG_WIDTH (SEG_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  // decouple classification from emission
  acrle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .pop_entry  (pop_entry)
  );

  // build segments and emit words through the output register
  acrle_back #(
    .SEG_WIDTH (SEG_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (pop_entry),
    .q_pop       (pop),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .m_word      (word),
    .m_last      (m_tlast),
    .m_seg_words (seg_words),
    .m_vis       (vis_total)
  );

  // pack result fields, lowest field first, pad to whole bytes
  assign m_tdata = {2'b00, vis_total, seg_words, word};

endmodule
